### design/bmis_pkg.sv
// Shared types and constants for the bitmap id set.
`timescale 1ns / 1ps

package bmis_pkg;

  // Fixed field widths of the item, result and configuration ports
  localparam int OP_W  = 3;
  localparam int ID_W  = 10;
  localparam int CNT_W = 11;
  localparam int CFG_W = 11;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  // Opcodes as they arrive on in_opcode
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
  localparam logic [OP_W-1:0] OP_FIRST    = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT     = 3'd4;
  localparam logic [OP_W-1:0] OP_COUNT    = 3'd5;

  // Decoded command kind; unused opcodes become a no-op
  typedef enum logic [2:0] {
    K_CLEAR,
    K_ADD,
    K_CONTAINS,
    K_FIRST,
    K_NEXT,
    K_COUNT,
    K_NOP
  } cmd_kind_t;

  // Classified command as it travels through the queue
  typedef struct packed {
    cmd_kind_t         kind;
    logic [ID_W-1:0]   id;
    logic              oob;   // id rejected by range check
  } cmd_t;

  // Queue status seen by the busy logic and the back
  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  // Execution unit states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LOOK,
    ST_SCAN
  } st_t;

endpackage

### design/bitmap_id_set_with_iterator.sv
// Top level of the bitmap id set with ordered iterator.
`timescale 1ns / 1ps

// Membership set over ids below ID_CAPACITY, kept as a bitmap in a memory of
// WORD_BITS-bit words with one write port and one registered read port
// (ID_CAPACITY/WORD_BITS words, 32 by default).
// An item is taken when start is high and busy is low; each item gives exactly
// one result, shown for one cycle with out_strobe, which the receiver must
// take. Items pass through a two-entry queue to the execution unit, so up to
// two may be accepted while one is still at work. In the execution unit first
// and next scan memory words up to the word holding the largest member, at
// most ID_CAPACITY/WORD_BITS of them, and clear runs a zeroing sweep over
// every memory word. After reset the same sweep runs with busy high.
// WORD_BITS must be a power of two. size_in_use may be written at any time the
// block is idle; cfg_ready is always high.
module bitmap_id_set_with_iterator import bmis_pkg::*; #(
  parameter int ID_CAPACITY = 1024,
  parameter int WORD_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_size_in_use,
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [ID_W-1:0]  in_id,
  output logic             out_strobe,
  output logic             out_status,
  output logic             out_found,
  output logic [ID_W-1:0]  out_id_out,
  output logic             out_at_end,
  output logic [CNT_W-1:0] out_member_count
);

  logic    accept;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    pop_cmd;
  q_stat_t q_stat;
  logic    init_active;

  // Hold off items while the queue is full or memory is being zeroed after reset
  assign busy   = q_stat.full | init_active;
  assign accept = start & ~busy;

  bmis_front #(
    .ID_CAPACITY (ID_CAPACITY)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_size_in_use (cfg_size_in_use),
    .accept          (accept),
    .in_opcode       (in_opcode),
    .in_id           (in_id),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  bmis_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  bmis_back #(
    .ID_CAPACITY (ID_CAPACITY),
    .WORD_BITS   (WORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_cmd            (pop_cmd),
    .q_pop            (pop),
    .init_active      (init_active),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_id_out       (out_id_out),
    .out_at_end       (out_at_end),
    .out_member_count (out_member_count)
  );

endmodule

### design/bmis_front.sv
// Front end: configuration register, opcode decode and range check.
`timescale 1ns / 1ps

module bmis_front import bmis_pkg::*; #(
  parameter int ID_CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_size_in_use,
  input  logic             accept,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [ID_W-1:0]  in_id,
  output logic             push,
  output cmd_t             push_cmd
);

  logic [CFG_W-1:0] size_r;
  logic [CFG_W-1:0] size_nxt;
  logic             cap_oob;
  logic             size_oob;

  // Hold the size register; writes are always taken
  assign cfg_ready = 1'b1;
  assign size_nxt  = (cfg_valid && cfg_ready) ? cfg_size_in_use : size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  // Range checks against capacity and the configured size
  assign cap_oob  = (32'(in_id) >= 32'(ID_CAPACITY));
  assign size_oob = ({1'b0, in_id} >= size_r);

  // Classify the item and push it into the queue
  assign push = accept;

  always_comb begin
    push_cmd.id   = in_id;
    push_cmd.kind = K_NOP;
    push_cmd.oob  = 1'b0;
    unique case (in_opcode)
      OP_CLEAR:    push_cmd.kind = K_CLEAR;
      OP_ADD: begin
        push_cmd.kind = K_ADD;
        push_cmd.oob  = cap_oob | size_oob;
      end
      OP_CONTAINS: begin
        push_cmd.kind = K_CONTAINS;
        push_cmd.oob  = cap_oob;
      end
      OP_FIRST:    push_cmd.kind = K_FIRST;
      OP_NEXT:     push_cmd.kind = K_NEXT;
      OP_COUNT:    push_cmd.kind = K_COUNT;
      default:     push_cmd.kind = K_NOP;
    endcase
  end

endmodule

### design/bmis_cmdq.sv
// Two-entry command queue between the front end and the execution unit.
`timescale 1ns / 1ps

module bmis_cmdq import bmis_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t stat
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.avail = (cnt_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### design/bmis_back.sv
// Execution unit: bitmap memory, set state, word scanner and results.
`timescale 1ns / 1ps

module bmis_back import bmis_pkg::*; #(
  parameter int ID_CAPACITY = 1024,
  parameter int WORD_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  cmd_t             q_cmd,
  output logic             q_pop,
  output logic             init_active,
  output logic             out_strobe,
  output logic             out_status,
  output logic             out_found,
  output logic [ID_W-1:0]  out_id_out,
  output logic             out_at_end,
  output logic [CNT_W-1:0] out_member_count
);

  // WORD_BITS is a power of two: the bit index is the low part of an id
  localparam int NUM_WORDS = (ID_CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  function automatic logic [WADDR_W-1:0] word_of(input logic [ID_W-1:0] id);
    return WADDR_W'(id >> BIT_W);
  endfunction

  logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];

  st_t                  state_r, state_nxt;
  logic [WADDR_W-1:0]   sweep_r, sweep_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [WADDR_W-1:0]   scan_w_r, scan_w_nxt;
  logic [BIT_W-1:0]     scan_b_r, scan_b_nxt;
  logic [ID_W-1:0]      largest_r, largest_nxt;
  logic                 set_empty_r, set_empty_nxt;
  logic [ID_W-1:0]      cursor_r, cursor_nxt;
  logic                 cursor_valid_r, cursor_valid_nxt;
  logic [CNT_W-1:0]     mcount_r, mcount_nxt;
  logic [WORD_BITS-1:0] rd_data_r;

  logic                 strobe_nxt;
  logic                 status_nxt;
  logic                 found_nxt;
  logic [ID_W-1:0]      id_out_nxt;
  logic                 at_end_nxt;
  logic [CNT_W-1:0]     count_nxt;

  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic [WADDR_W-1:0]   rd_addr;

  logic                 sweep_last;
  logic                 dispatch;
  logic                 contains_go;
  logic                 next_ok;
  logic [ID_W-1:0]      next_start;
  logic                 look_bit;
  logic [WORD_BITS-1:0] scan_bits;
  logic [WORD_BITS-1:0] scan_iso;
  logic                 scan_hit;
  logic [BIT_W-1:0]     scan_idx;
  logic [ID_W-1:0]      hit_id;

  // Shared decisions
  assign init_active = (state_r == ST_INIT);
  assign sweep_last  = (sweep_r == LAST_WORD);
  assign dispatch    = (state_r == ST_IDLE) && q_stat.avail;
  assign contains_go = !q_cmd.oob && !set_empty_r && (q_cmd.id <= largest_r);
  assign next_ok     = cursor_valid_r && !set_empty_r && (cursor_r < largest_r);
  assign next_start  = cursor_r + ID_W'(1);
  assign look_bit    = rd_data_r[cmd_r.id[BIT_W-1:0]];

  // Drop bits below the start position, then isolate the lowest member
  assign scan_bits = rd_data_r & ({WORD_BITS{1'b1}} << scan_b_r);
  assign scan_iso  = scan_bits & (~scan_bits + WORD_BITS'(1));
  assign scan_hit  = |scan_bits;

  always_comb begin
    scan_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (scan_iso[j]) begin
        scan_idx = scan_idx | BIT_W'(j);
      end
    end
  end

  assign hit_id = ID_W'({scan_w_r, scan_idx});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        if (sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_stat.avail) begin
          priority if (q_cmd.kind == K_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if ((q_cmd.kind == K_ADD && !q_cmd.oob) ||
                       (q_cmd.kind == K_CONTAINS && contains_go)) begin
            state_nxt = ST_LOOK;
          end else if ((q_cmd.kind == K_FIRST && !set_empty_r) ||
                       (q_cmd.kind == K_NEXT && next_ok)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LOOK: state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory control and results
  always_comb begin
    sweep_nxt        = sweep_r;
    cmd_nxt          = cmd_r;
    scan_w_nxt       = scan_w_r;
    scan_b_nxt       = scan_b_r;
    largest_nxt      = largest_r;
    set_empty_nxt    = set_empty_r;
    cursor_nxt       = cursor_r;
    cursor_valid_nxt = cursor_valid_r;
    mcount_nxt       = mcount_r;
    q_pop            = 1'b0;
    mem_we           = 1'b0;
    mem_wa           = sweep_r;
    mem_wd           = '0;
    rd_addr          = '0;
    strobe_nxt       = 1'b0;
    status_nxt       = 1'b0;
    found_nxt        = 1'b0;
    id_out_nxt       = '0;
    at_end_nxt       = 1'b0;
    count_nxt        = '0;
    unique case (state_r)
      // Zero one word a cycle
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + WADDR_W'(1);
      end
      ST_IDLE: begin
        if (dispatch) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          unique case (q_cmd.kind)
            K_CLEAR: begin
              largest_nxt      = '0;
              set_empty_nxt    = 1'b1;
              cursor_nxt       = '0;
              cursor_valid_nxt = 1'b0;
              mcount_nxt       = '0;
              sweep_nxt        = '0;
              strobe_nxt       = 1'b1;
            end
            K_ADD: begin
              rd_addr = word_of(q_cmd.id);
              if (q_cmd.oob) begin
                strobe_nxt = 1'b1;
                status_nxt = 1'b1;
              end
            end
            K_CONTAINS: begin
              rd_addr = word_of(q_cmd.id);
              if (!contains_go) begin
                strobe_nxt = 1'b1;
              end
            end
            K_FIRST: begin
              scan_w_nxt = '0;
              scan_b_nxt = '0;
              if (set_empty_r) begin
                strobe_nxt = 1'b1;
                at_end_nxt = 1'b1;
              end
            end
            K_NEXT: begin
              rd_addr    = word_of(next_start);
              scan_w_nxt = word_of(next_start);
              scan_b_nxt = next_start[BIT_W-1:0];
              if (!next_ok) begin
                strobe_nxt = 1'b1;
                at_end_nxt = 1'b1;
              end
            end
            K_COUNT: begin
              strobe_nxt = 1'b1;
              count_nxt  = mcount_r;
              if (!set_empty_r) begin
                cursor_nxt       = largest_r;
                cursor_valid_nxt = 1'b1;
              end
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      // Word data is back: finish add or contains
      ST_LOOK: begin
        strobe_nxt = 1'b1;
        if (cmd_r.kind == K_ADD) begin
          mem_we = 1'b1;
          mem_wa = word_of(cmd_r.id);
          mem_wd = rd_data_r | (WORD_BITS'(1) << cmd_r.id[BIT_W-1:0]);
          if (!look_bit) begin
            mcount_nxt = mcount_r + CNT_W'(1);
          end
          if (set_empty_r || cmd_r.id > largest_r) begin
            largest_nxt = cmd_r.id;
          end
          set_empty_nxt = 1'b0;
        end else begin
          found_nxt = look_bit;
        end
      end
      // Check one word a cycle while the following word is read
      ST_SCAN: begin
        rd_addr = (scan_w_r == LAST_WORD) ? scan_w_r : scan_w_r + WADDR_W'(1);
        if (scan_hit) begin
          cursor_nxt       = hit_id;
          cursor_valid_nxt = 1'b1;
          strobe_nxt       = 1'b1;
          id_out_nxt       = hit_id;
        end else begin
          scan_w_nxt = rd_addr;
          scan_b_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // Control and set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_INIT;
      sweep_r        <= '0;
      largest_r      <= '0;
      set_empty_r    <= 1'b1;
      cursor_r       <= '0;
      cursor_valid_r <= 1'b0;
      mcount_r       <= '0;
      out_strobe     <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sweep_r        <= sweep_nxt;
      largest_r      <= largest_nxt;
      set_empty_r    <= set_empty_nxt;
      cursor_r       <= cursor_nxt;
      cursor_valid_r <= cursor_valid_nxt;
      mcount_r       <= mcount_nxt;
      out_strobe     <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r            <= cmd_nxt;
    scan_w_r         <= scan_w_nxt;
    scan_b_r         <= scan_b_nxt;
    out_status       <= status_nxt;
    out_found        <= found_nxt;
    out_id_out       <= id_out_nxt;
    out_at_end       <= at_end_nxt;
    out_member_count <= count_nxt;
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= bitmap_mem[rd_addr];
  end

  // The member count tracks emptiness
  a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
    set_empty_r == (mcount_r == '0))
    else $error("member count disagrees with empty flag");

  // A valid cursor never passes the largest member
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_valid_r |-> (cursor_r <= largest_r))
    else $error("cursor beyond largest member");

  // A scan always finds a member before running off the last word
  a_scan_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !scan_hit) |-> (scan_w_r != LAST_WORD))
    else $error("scan missed the largest member");

  // An empty set has no valid cursor
  a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    set_empty_r |-> !cursor_valid_r)
    else $error("cursor valid on empty set");

endmodule
